// File: hdl/lkvc_pkg.sv
package lkvc_pkg;

  localparam int CAP_W          = 5;
  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int STAMP_W        = 32;
  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

// File: hdl/lkvc_ctrl.sv
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        // hold the input off while reset is applied
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the result register can take the result
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/lkvc_dp.sv
module lkvc_dp import lkvc_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_wdata,
  input  logic                    op,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [VAL_W-1:0] value,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]      capacity;
  op_t                   req_op;
  logic [KEY_W-1:0]      req_key;
  logic [VAL_W-1:0]      req_value;
  logic [CNT_W-1:0]      cnt;
  logic [ENTRIES-1:0]    valid;
  logic [STAMP_W-1:0]    stamp_counter;

  logic [KEY_W-1:0]      key_mem   [ENTRIES];
  logic [VAL_W-1:0]      value_mem [ENTRIES];
  logic [COUNT_BITS-1:0] count_mem [ENTRIES];
  logic [STAMP_W-1:0]    stamp_mem [ENTRIES];

  logic [KEY_W-1:0]      rd_key;
  logic [VAL_W-1:0]      rd_value;
  logic [COUNT_BITS-1:0] rd_count;
  logic [STAMP_W-1:0]    rd_stamp;

  logic                  found;
  logic [IDX_W-1:0]      found_idx;
  logic [VAL_W-1:0]      found_value;
  logic [COUNT_BITS-1:0] found_count;
  logic [STAMP_W-1:0]    found_stamp;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [CNT_W-1:0]      used;
  logic                  vic_found;
  logic [IDX_W-1:0]      vic_idx;
  logic [COUNT_BITS-1:0] vic_count;
  logic [STAMP_W-1:0]    vic_age;

  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      proc_idx;
  logic                  proc_en;
  logic                  e_valid;
  logic [STAMP_W-1:0]    age;
  logic                  take_victim;

  logic [CW-1:0]         cap_eff;
  logic [CW-1:0]         used_ext;
  logic                  count_sat;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [VAL_W-1:0]      wr_value;
  logic [COUNT_BITS-1:0] wr_count;
  logic [STAMP_W-1:0]    wr_stamp;
  logic                  set_valid;
  logic                  stamp_adv;
  logic                  res_evict;
  logic [VAL_W-1:0]      res_read;
  logic                  out_free;

  // scan: read address runs one ahead of the entry being examined
  assign rd_addr     = cnt[IDX_W-1:0];
  assign proc_idx    = IDX_W'(cnt - CNT_W'(1));
  assign proc_en     = cmd.scan && (cnt != '0);
  assign e_valid     = valid[proc_idx];
  assign age         = stamp_counter - rd_stamp;
  assign take_victim = e_valid && (!vic_found || (rd_count < vic_count) ||
                       ((rd_count == vic_count) && (age > vic_age)));

  assign out_free         = !out_valid || !out_stall;
  assign status.scan_last = cmd.scan && (cnt == CNT_W'(ENTRIES));
  assign status.out_free  = out_free;

  always_comb begin
    cap_eff   = (CW'(capacity) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(capacity);
    used_ext  = CW'(used);
    count_sat = (found_count == {COUNT_BITS{1'b1}});
    wr_en     = 1'b0;
    wr_idx    = found_idx;
    wr_value  = found_value;
    wr_count  = count_sat ? found_count : found_count + COUNT_BITS'(1);
    wr_stamp  = count_sat ? found_stamp : stamp_counter;
    set_valid = 1'b0;
    stamp_adv = 1'b0;
    res_evict = 1'b0;
    res_read  = '0;
    if (req_op == OP_GET) begin
      res_read = found ? found_value : MISS_VALUE;
      if (found && !count_sat) begin
        wr_en     = 1'b1;
        stamp_adv = 1'b1;
      end
    end else if (cap_eff != '0) begin
      wr_value = req_value;
      if (found) begin
        wr_en     = 1'b1;
        stamp_adv = !count_sat;
      end else begin
        wr_en     = 1'b1;
        set_valid = 1'b1;
        stamp_adv = 1'b1;
        wr_count  = COUNT_BITS'(1);
        wr_stamp  = stamp_counter;
        if (used_ext >= cap_eff) begin
          // full: reuse the least frequently used slot
          wr_idx    = vic_idx;
          res_evict = 1'b1;
        end else begin
          wr_idx = free_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      key_mem[wr_idx]   <= req_key;
      value_mem[wr_idx] <= wr_value;
      count_mem[wr_idx] <= wr_count;
      stamp_mem[wr_idx] <= wr_stamp;
    end
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
    rd_count <= count_mem[rd_addr];
    rd_stamp <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op     <= op_t'(op);
      req_key    <= key;
      req_value  <= value;
      found      <= 1'b0;
      free_found <= 1'b0;
      vic_found  <= 1'b0;
      used       <= '0;
    end else if (proc_en) begin
      if (e_valid) begin
        used <= used + CNT_W'(1);
        if (!found && (rd_key == req_key)) begin
          found       <= 1'b1;
          found_idx   <= proc_idx;
          found_value <= rd_value;
          found_count <= rd_count;
          found_stamp <= rd_stamp;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= proc_idx;
      end
      if (take_victim) begin
        vic_found <= 1'b1;
        vic_idx   <= proc_idx;
        vic_count <= rd_count;
        vic_age   <= age;
      end
    end
    if (cmd.commit) begin
      hit        <= found;
      read_value <= res_read;
      evicted    <= res_evict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      cnt           <= '0;
      valid         <= '0;
      stamp_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.scan) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.commit && set_valid) begin
        valid[wr_idx] <= 1'b1;
      end
      if (cmd.commit && stamp_adv) begin
        stamp_counter <= stamp_counter + STAMP_W'(1);
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/lfu_key_value_cache_unit.sv
// Key/value store with least-frequently-used replacement.
// Input channel (in_valid/in_stall): op (0 get, 1 put), key, value. One result
// per transfer on the output channel (out_valid/out_stall): hit, read_value
// (stored value on a get hit, all ones on a get miss, zero for a put) and
// evicted (a put of a new key into a full store removed the entry with the
// lowest use count, oldest first on ties).
// Each request walks all ENTRIES slots through the entry memory, one slot a
// cycle, then commits its result to the output register; a new item is not
// taken while one is in flight, and the next item is taken as soon as the
// previous result is in the output register.
// capacity is written through cfg_we/cfg_wdata; the user must write it only
// while no request is in flight, and the block itself does not enforce this.
// Zero disables insertion, values above ENTRIES act as ENTRIES.
// Reset (rst, synchronous) empties the store, clears the stamp counter, sets
// capacity to 16, drops any pending result and holds in_stall high.
// While out_stall is high the result holds; a request that finishes meanwhile
// waits in the controller, and in_stall stays high until the held result is
// taken.
module lfu_key_value_cache_unit import lkvc_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    op,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted
);

  cmd_t    cmd;
  status_t status;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lkvc_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .op         (op),
    .key        (key),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted)
  );

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("result committed over an undelivered result");

  a_rise_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

  a_evict_is_put_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted) |-> (!hit && (read_value == '0)))
    else $error("eviction reported on a hit or a get");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

endmodule
